### src/debounced_counter_seven_segment_scan_macros.svh
// Assertion macros shared by the press counter display block.
`ifndef DEBOUNCED_COUNTER_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define DEBOUNCED_COUNTER_SEVEN_SEGMENT_SCAN_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define DCSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dcss check failed: same-cycle implication");

// next-cycle implication, sampled on clock, off during reset
`define DCSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dcss check failed: next-cycle implication");

`endif

### src/dcss_pkg.sv
// Types, constants and display functions of the press counter display block.
package dcss_pkg;

   localparam logic [13:0] COUNT_MAX        = 14'd9999;
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd100;
   localparam logic [15:0] BLINK_RESET      = 16'd1000;
   localparam logic [3:0]  BLANK_CODE       = 4'd10;
   localparam logic [3:0]  DIGIT_NINE       = 4'd9;

   localparam logic        CSR_DEBOUNCE_SAMPLES = 1'b0;
   localparam logic        CSR_BLINK_RELOAD     = 1'b1;

   localparam logic [1:0]  POS_THOUSANDS = 2'd0;
   localparam logic [1:0]  POS_HUNDREDS  = 2'd1;
   localparam logic [1:0]  POS_TENS      = 2'd2;
   localparam logic [1:0]  POS_UNITS     = 2'd3;

   typedef struct packed {
      logic [3:0] th;
      logic [3:0] hu;
      logic [3:0] te;
      logic [3:0] un;
   } bcd_type;

   typedef struct packed {
      logic [13:0] count;
      bcd_type     digits;
   } count_state_type;

   typedef struct packed {
      logic [6:0]  segments;
      logic [3:0]  digit_enables_n;
      logic        status_led;
      logic [13:0] count_value;
   } rsp_word_type;

   function automatic logic [3:0] digit_code(input bcd_type d, input logic [1:0] pos);
      logic b0;
      logic b1;
      logic b2;
      logic [3:0] code;
      b0 = (d.th == 4'd0);
      b1 = b0 && (d.hu == 4'd0);
      b2 = b1 && (d.te == 4'd0);
      unique case (pos)
         POS_THOUSANDS: code = b0 ? BLANK_CODE : d.th;
         POS_HUNDREDS:  code = b1 ? BLANK_CODE : d.hu;
         POS_TENS:      code = b2 ? BLANK_CODE : d.te;
         POS_UNITS:     code = d.un;
         default:       code = d.un;
      endcase
      return code;
   endfunction

   function automatic logic [6:0] seg_pattern(input logic [3:0] code);
      logic [6:0] pat;
      unique case (code)
         4'd0:    pat = 7'h3f;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5b;
         4'd3:    pat = 7'h4f;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6d;
         4'd6:    pat = 7'h7d;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7f;
         4'd9:    pat = 7'h6f;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

### src/dcss_channels.sv
// Valid/ready channel interfaces for sample words and result words.
interface dcss_req_if;
   logic valid;
   logic ready;
   logic button_level;
   logic scan_tick;

   modport source (output valid, output button_level, output scan_tick, input ready);
   modport sink   (input valid, input button_level, input scan_tick, output ready);
endinterface

interface dcss_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] segments;
   logic [3:0] digit_enables_n;
   logic       status_led;
   logic [13:0] count_value;

   modport source (output valid, output segments, output digit_enables_n,
                   output status_led, output count_value, input ready);
   modport sink   (input valid, input segments, input digit_enables_n,
                   input status_led, input count_value, output ready);
endinterface

### src/debounced_counter_seven_segment_scan.sv
// Top level: debounced press counter driving a scanned four-digit display.
// Each accepted sample word's result goes to the output register, or to the skid entry if that is held.
// Throughput: one sample word per cycle while the skid entry is empty; the
// two-entry output buffer lets a word enter while a result is held by the sink.
// Reset (synchronous): count, phase, scan and latch state clear; debounce and
// blink counts and registers go to 100/1000 samples/ticks; output buffer empties.
`include "debounced_counter_seven_segment_scan_macros.svh"

module debounced_counter_seven_segment_scan
   import dcss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dcss_req_if.sink    req_ch,
   dcss_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] debounce_samples_ff;
   logic [15:0] blink_reload_ff;

   logic        accept;
   logic        take;
   count_state_type count_next;

   logic [15:0] blink_rem_ff, blink_rem_in;
   logic        blink_phase_ff, blink_phase_in;
   logic        led_ff, led_in;
   logic [1:0]  scan_ff, scan_in;
   logic [6:0]  segment_latch_ff, segment_latch_in;
   logic [3:0]  enable_latch_ff, enable_latch_in;
   logic [15:0] blink_base;

   rsp_word_type word_in;
   rsp_word_type out_word_ff, skid_word_ff;
   logic         out_valid_ff, skid_valid_ff;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && !skid_valid_ff;
   assign take         = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_samples_ff <= DEBOUNCE_RESET;
         blink_reload_ff     <= BLINK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_SAMPLES: debounce_samples_ff <= csr_write_data;
            CSR_BLINK_RELOAD:     blink_reload_ff     <= csr_write_data;
            default:              debounce_samples_ff <= debounce_samples_ff;
         endcase
      end
   end

   dcss_press_counter u_counter (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .button_level     (req_ch.button_level),
      .debounce_samples (debounce_samples_ff),
      .count_next       (count_next)
   );

   always_comb begin
      blink_rem_in     = blink_rem_ff;
      blink_phase_in   = blink_phase_ff;
      led_in           = led_ff;
      scan_in          = scan_ff;
      segment_latch_in = segment_latch_ff;
      enable_latch_in  = enable_latch_ff;
      blink_base       = blink_rem_ff;
      if (accept && req_ch.scan_tick) begin
         if (blink_rem_ff == 16'd0) begin
            blink_base     = blink_reload_ff;
            led_in         = blink_phase_ff;
            blink_phase_in = !blink_phase_ff;
         end
         blink_rem_in     = blink_base - 16'd1;
         enable_latch_in  = ~(4'b0001 << scan_ff);
         segment_latch_in = seg_pattern(digit_code(count_next.digits, scan_ff));
         scan_in          = scan_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_rem_ff     <= BLINK_RESET;
         blink_phase_ff   <= 1'b0;
         led_ff           <= 1'b0;
         scan_ff          <= 2'd0;
         segment_latch_ff <= 7'd0;
         enable_latch_ff  <= 4'd0;
      end else begin
         blink_rem_ff     <= blink_rem_in;
         blink_phase_ff   <= blink_phase_in;
         led_ff           <= led_in;
         scan_ff          <= scan_in;
         segment_latch_ff <= segment_latch_in;
         enable_latch_ff  <= enable_latch_in;
      end
   end

   assign word_in = '{segments:        segment_latch_in,
                      digit_enables_n: enable_latch_in,
                      status_led:      led_in,
                      count_value:     count_next.count};

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         out_word_ff <= skid_word_ff;
      end else if (accept && (take || !out_valid_ff)) begin
         out_word_ff <= word_in;
      end
      if (accept && out_valid_ff && !take) begin
         skid_word_ff <= word_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.segments        = out_word_ff.segments;
   assign rsp_ch.digit_enables_n = out_word_ff.digit_enables_n;
   assign rsp_ch.status_led      = out_word_ff.status_led;
   assign rsp_ch.count_value     = out_word_ff.count_value;

   `DCSS_ASSERT_NOW(a_count_in_range, 1'b1, count_next.count <= COUNT_MAX)
   `DCSS_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `DCSS_ASSERT_NEXT(a_tick_one_digit, accept && req_ch.scan_tick, $countones(enable_latch_ff) == 3)
   `DCSS_ASSERT_NEXT(a_latch_hold, !reset && !(accept && req_ch.scan_tick), $stable(enable_latch_ff) && $stable(segment_latch_ff) && $stable(led_ff))

endmodule

### src/dcss_press_counter.sv
// Button debouncer with saturating binary and BCD press count.
module dcss_press_counter
   import dcss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            button_level,
   input  logic [15:0]     debounce_samples,
   output count_state_type count_next
);

   logic        phase_ff, phase_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [13:0] count_ff, count_in;
   bcd_type     digits_ff, digits_in;
   logic        complete;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      complete     = 1'b0;
      if (accept) begin
         if (button_level == !phase_ff) begin
            if (remaining_ff <= 16'd1) begin
               remaining_in = debounce_samples;
               phase_in     = !phase_ff;
               complete     = phase_ff;
            end else begin
               remaining_in = remaining_ff - 16'd1;
            end
         end else begin
            remaining_in = debounce_samples;
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      digits_in = digits_ff;
      if (complete && (count_ff < COUNT_MAX)) begin
         count_in = count_ff + 14'd1;
         if (digits_ff.un == DIGIT_NINE) begin
            digits_in.un = 4'd0;
            if (digits_ff.te == DIGIT_NINE) begin
               digits_in.te = 4'd0;
               if (digits_ff.hu == DIGIT_NINE) begin
                  digits_in.hu = 4'd0;
                  digits_in.th = digits_ff.th + 4'd1;
               end else begin
                  digits_in.hu = digits_ff.hu + 4'd1;
               end
            end else begin
               digits_in.te = digits_ff.te + 4'd1;
            end
         end else begin
            digits_in.un = digits_ff.un + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         remaining_ff <= DEBOUNCE_RESET;
         count_ff     <= 14'd0;
         digits_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
         digits_ff    <= digits_in;
      end
   end

   assign count_next = '{count: count_in, digits: digits_in};

endmodule
